/* design/line_aligned_round_robin_splitter_assert.svh */
// Assertion macros for the line-aligned splitter
`ifndef LINE_ALIGNED_ROUND_ROBIN_SPLITTER_ASSERT_SVH
`define LINE_ALIGNED_ROUND_ROBIN_SPLITTER_ASSERT_SVH
`ifndef SYNTHESIS
`define LARRS_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LARRS_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LARRS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define LARRS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* design/larrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// larrs_pkg
// Shared types and constants of the line-aligned round-robin splitter.
// ---------------------------------------------------------------------------
package larrs_pkg;
   localparam int MAX_BATCH_DEF   = 4096;
   localparam int MAX_OUTPUTS_DEF = 16;
   localparam logic [7:0] NL_CHAR = 8'd10;

   localparam logic [1:0] REG_BATCH  = 2'd0;
   localparam logic [1:0] REG_NOUT   = 2'd1;
   localparam logic [1:0] REG_BMODE  = 2'd2;
   localparam logic [1:0] REG_HDR    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_EMIT,
      ST_MAIN,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic [12:0] batch_len;
      logic [4:0]  num_outputs;
      logic        byte_mode;
      logic        header_enable;
   } cfg_type;
endpackage
`default_nettype wire

/* design/line_aligned_round_robin_splitter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// line_aligned_round_robin_splitter
// Turns a byte stream into block descriptors for a copy engine.
// ---------------------------------------------------------------------------
// Usage:
//  req_ takes one stream word per cycle while req_stall is low: a data
//  byte and end_of_stream. rsp_ gives block descriptors; last_of_run marks
//  the final one a word causes. The psel/penable port is APB-style, for
//  the batch length, num_outputs, byte_mode and header_enable registers;
//  write it only while idle. A word that closes no batch leaves the block
//  idle. A word that closes a batch raises req_stall until all its
//  descriptors are taken: in byte mode the descriptor is loaded in ST_EMIT,
//  in the main phase in ST_MAIN and a tail block in ST_TAIL after it, each
//  once the output register is free. The word that closes the initial
//  buffer first runs a shift-subtract divider for the share (the fill count
//  over the outputs), then scans the newline memory backward through its
//  single read port one entry at a time and loads one descriptor per output.
//  Reset returns the registers to their defaults and the stream state to
//  offset 0 and id 0; the newline memory needs no clearing. While
//  rsp_stall is high the pending descriptor holds and no new word is taken.
// ---------------------------------------------------------------------------
module line_aligned_round_robin_splitter #(
   parameter int MAX_BATCH   = larrs_pkg::MAX_BATCH_DEF,
   parameter int MAX_OUTPUTS = larrs_pkg::MAX_OUTPUTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_destination,
   output logic [31:0]      rsp_block_id,
   output logic [39:0]      rsp_start_offset,
   output logic [16:0]      rsp_block_length,
   output logic             rsp_complete,
   output logic             rsp_with_header,
   output logic             rsp_last_of_run,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import larrs_pkg::*;
   `include "line_aligned_round_robin_splitter_assert.svh"

   localparam int MAPD = MAX_BATCH * MAX_OUTPUTS;
   localparam int AW   = (MAPD > 1) ? $clog2(MAPD) : 1;
   localparam int CW   = $clog2(MAPD + 1);

   // configuration registers
   cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{batch_len: 13'd4096, num_outputs: 5'd2,
                     byte_mode: 1'b0, header_enable: 1'b1};
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_BATCH: cfg_ff.batch_len     <= pwdata[12:0];
            REG_NOUT:  cfg_ff.num_outputs   <= pwdata[4:0];
            REG_BMODE: cfg_ff.byte_mode     <= pwdata[0];
            REG_HDR:   cfg_ff.header_enable <= pwdata[0];
            default: ;
         endcase
      end
   end
   assign pready = 1'b1;
   always_comb begin
      case (paddr[3:2])
         REG_BATCH: prdata = {19'd0, cfg_ff.batch_len};
         REG_NOUT:  prdata = {27'd0, cfg_ff.num_outputs};
         REG_BMODE: prdata = {31'd0, cfg_ff.byte_mode};
         REG_HDR:   prdata = {31'd0, cfg_ff.header_enable};
         default:   prdata = 32'd0;
      endcase
   end

   // clamp registers
   logic [CW-1:0] bsz, nout, full_sz;
   always_comb begin
      if (cfg_ff.batch_len == 13'd0) bsz = CW'(1);
      else if (32'(cfg_ff.batch_len) > MAX_BATCH) bsz = CW'(MAX_BATCH);
      else bsz = CW'(cfg_ff.batch_len);
      if (cfg_ff.num_outputs == 5'd0) nout = CW'(1);
      else if (32'(cfg_ff.num_outputs) > MAX_OUTPUTS) nout = CW'(MAX_OUTPUTS);
      else nout = CW'(cfg_ff.num_outputs);
   end
   // size of the initial buffer
   assign full_sz = CW'(bsz * nout);

   // stream state
   state_type     state_ff, state_in;
   logic [CW-1:0] fill_ff, lnl_ff;
   logic          lnl_v_ff, init_ff, eos_ff;
   logic [3:0]    cur_ff;
   logic [31:0]   bid_ff;
   logic [CW-1:0] carry_ff;
   logic [39:0]   off_ff;

   // scan state
   logic [CW-1:0] len_ff, share_ff, start_ff, pos_ff;
   logic [5:0]    k_ff;
   logic          rd_pend_ff;

   // share divider state
   logic [CW-1:0] div_quo_ff, div_rem_ff;
   logic [4:0]    div_cnt_ff;
   logic [CW-1:0] div_shift, div_quo_next, share_sel;
   logic          div_bit;
   assign div_shift    = {div_rem_ff[CW-2:0], div_quo_ff[CW-1]};
   assign div_bit      = div_shift >= nout;
   assign div_quo_next = {div_quo_ff[CW-2:0], div_bit};
   assign share_sel    = (len_ff < full_sz) ? div_quo_next : bsz;

   // map port
   logic          wr_en, rd_q;
   logic [AW-1:0] rd_addr;
   larrs_map #(.DEPTH(MAPD), .AW(AW)) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff[AW-1:0]),
      .wr_data(req_data_byte == NL_CHAR),
      .rd_addr(rd_addr),
      .rd_data(rd_q)
   );

   // output register
   logic          ov_ff;
   logic [3:0]    od_ff;
   logic [31:0]   oid_ff;
   logic [39:0]   ooff_ff;
   logic [16:0]   olen_ff;
   logic          oc_ff, oh_ff, ol_ff;
   logic          out_free;
   assign out_free = !ov_ff || !rsp_stall;

   assign rsp_valid        = ov_ff;
   assign rsp_destination  = od_ff;
   assign rsp_block_id     = oid_ff;
   assign rsp_start_offset = ooff_ff;
   assign rsp_block_length = olen_ff;
   assign rsp_complete     = oc_ff;
   assign rsp_with_header  = oh_ff;
   assign rsp_last_of_run  = ol_ff;

   logic acc;
   assign req_stall = (state_ff != ST_IDLE) || ov_ff;
   assign acc = req_valid && !req_stall;
   assign wr_en = acc && (fill_ff < CW'(MAPD));

   logic [CW-1:0] fill_new;
   assign fill_new = wr_en ? fill_ff + CW'(1) : fill_ff;
   logic [CW-1:0] half;
   assign half = (len_ff != '0) ? (len_ff - CW'(1)) >> 1 : '0;
   logic is_last_nout;
   assign is_last_nout = (CW'(k_ff) + CW'(1)) >= nout;

   // cut point of a main-phase batch
   logic tail_need;
   logic cut;
   logic [CW-1:0] head;
   assign cut  = (len_ff != '0) && lnl_v_ff && (lnl_ff >= half);
   assign head = lnl_ff + CW'(1);
   assign tail_need = cut && (len_ff != head);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (cfg_ff.byte_mode) begin
                  if (fill_new >= bsz || req_end_of_stream) state_in = ST_EMIT;
               end else if (init_ff) begin
                  if (fill_new >= full_sz || req_end_of_stream) state_in = ST_DIV;
               end else if (fill_new >= bsz || req_end_of_stream) begin
                  state_in = ST_MAIN;
               end
            end
         end
         ST_DIV: if (div_cnt_ff == 5'(CW - 1)) state_in = ST_SCAN;
         ST_SCAN: if (rd_pend_ff && out_free) begin
            if (is_last_nout || rd_q || pos_ff <= start_ff) state_in = ST_EMIT;
         end
         ST_EMIT: if (out_free) begin
            if (init_ff && !cfg_ff.byte_mode && !is_last_nout) state_in = ST_SCAN;
            else state_in = ST_IDLE;
         end
         ST_MAIN: if (out_free) state_in = (eos_ff && tail_need) ? ST_TAIL : ST_IDLE;
         ST_TAIL: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // map read address: scan position, or the last flag on the final share
   always_comb begin
      if (state_ff == ST_SCAN && is_last_nout) rd_addr = AW'(len_ff - CW'(1));
      else rd_addr = pos_ff[AW-1:0];
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; fill_ff <= '0; lnl_ff <= '0; lnl_v_ff <= 1'b0;
         init_ff <= 1'b1; cur_ff <= '0; bid_ff <= '0; carry_ff <= '0;
         off_ff <= '0; eos_ff <= 1'b0; ov_ff <= 1'b0; rd_pend_ff <= 1'b0;
         k_ff <= '0; pos_ff <= '0; start_ff <= '0; len_ff <= '0;
         share_ff <= '0; div_quo_ff <= '0; div_rem_ff <= '0; div_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (acc) begin
               fill_ff <= fill_new;
               eos_ff  <= req_end_of_stream;
               if (wr_en && req_data_byte == NL_CHAR) begin
                  lnl_ff <= fill_ff; lnl_v_ff <= 1'b1;
               end
               len_ff <= fill_new;
               if (state_in == ST_DIV) begin
                  div_quo_ff <= fill_new; div_rem_ff <= '0; div_cnt_ff <= '0;
                  k_ff <= '0; start_ff <= '0; rd_pend_ff <= 1'b0;
               end
               if (state_in != ST_IDLE) begin
                  fill_ff <= '0;
               end
            end
            // one quotient bit per cycle: fill count over outputs
            ST_DIV: begin
               div_rem_ff <= div_bit ? div_shift - nout : div_shift;
               div_quo_ff <= div_quo_next;
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (state_in == ST_SCAN) begin
                  share_ff <= share_sel;
                  pos_ff   <= share_sel;
               end
            end
            ST_SCAN: begin
               if (!rd_pend_ff) rd_pend_ff <= 1'b1;
               else if (out_free) begin
                  if (state_in == ST_EMIT) begin
                     ov_ff <= 1'b1; od_ff <= k_ff[3:0]; oid_ff <= bid_ff;
                     ooff_ff <= off_ff + 40'(start_ff); oh_ff <= cfg_ff.header_enable;
                     rd_pend_ff <= 1'b0;
                     if (is_last_nout) begin
                        olen_ff <= 17'((len_ff > start_ff) ? len_ff - start_ff : '0);
                        oc_ff <= ((len_ff != '0) && rd_q) || eos_ff;
                        ol_ff <= 1'b1;
                     end else begin
                        oc_ff <= 1'b1; ol_ff <= 1'b0;
                        if (rd_q) begin
                           olen_ff <= 17'(pos_ff + CW'(1) - start_ff);
                           start_ff <= pos_ff + CW'(1);
                        end else begin
                           olen_ff <= '0;
                        end
                     end
                  end else begin
                     pos_ff <= pos_ff - CW'(1); rd_pend_ff <= 1'b0;
                  end
               end
            end
            ST_EMIT: if (out_free) begin
               if (cfg_ff.byte_mode) begin
                  ov_ff <= 1'b1; od_ff <= cur_ff; oid_ff <= bid_ff; ooff_ff <= off_ff;
                  olen_ff <= 17'(carry_ff + len_ff); oc_ff <= 1'b1; oh_ff <= 1'b1;
                  ol_ff <= 1'b1;
                  off_ff <= off_ff + 40'(carry_ff + len_ff);
                  bid_ff <= bid_ff + 32'd1;
                  cur_ff <= 4'((CW'(cur_ff) + CW'(1) >= nout) ? '0 : CW'(cur_ff) + CW'(1));
                  carry_ff <= '0; lnl_v_ff <= 1'b0;
               end else if (!is_last_nout) begin
                  // each share before the last closes its own block
                  k_ff <= k_ff + 6'd1;
                  pos_ff <= CW'(k_ff + 6'd2) * share_ff;
                  bid_ff <= bid_ff + 32'd1;
               end else begin
                  if (oc_ff) bid_ff <= bid_ff + 32'd1;
                  cur_ff <= oc_ff ? 4'd0 : 4'(nout - CW'(1));
                  off_ff <= off_ff + 40'(len_ff);
                  init_ff <= 1'b0; lnl_v_ff <= 1'b0;
               end
               if (state_in == ST_IDLE && eos_ff) begin
                  lnl_v_ff <= 1'b0; init_ff <= 1'b1; cur_ff <= '0; bid_ff <= '0;
                  carry_ff <= '0; off_ff <= '0;
               end
            end
            ST_MAIN: if (out_free) begin
               ov_ff <= 1'b1; od_ff <= cur_ff; oid_ff <= bid_ff; ooff_ff <= off_ff;
               oh_ff <= cfg_ff.header_enable;
               lnl_v_ff <= 1'b0;
               ol_ff <= !(eos_ff && tail_need);
               if (cut) begin
                  olen_ff <= 17'(carry_ff + head); oc_ff <= 1'b1;
                  off_ff <= off_ff + 40'(carry_ff + head);
                  cur_ff <= 4'((CW'(cur_ff) + CW'(1) >= nout) ? '0 : CW'(cur_ff) + CW'(1));
                  carry_ff <= len_ff - head; bid_ff <= bid_ff + 32'd1;
               end else begin
                  olen_ff <= 17'(carry_ff + len_ff); oc_ff <= eos_ff;
                  off_ff <= off_ff + 40'(carry_ff + len_ff); carry_ff <= '0;
               end
               if (state_in == ST_IDLE && eos_ff) begin
                  init_ff <= 1'b1; cur_ff <= '0; bid_ff <= '0;
                  carry_ff <= '0; off_ff <= '0;
               end
            end
            ST_TAIL: if (out_free) begin
               // tail goes to the output of the batch just sent
               ov_ff <= 1'b1; oid_ff <= bid_ff; ooff_ff <= off_ff;
               olen_ff <= 17'(carry_ff); oc_ff <= 1'b1; ol_ff <= 1'b1;
               init_ff <= 1'b1; cur_ff <= '0; bid_ff <= '0;
               carry_ff <= '0; off_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   `LARRS_ASSERT_IMPL(a_no_take_busy, clock, reset,
      acc |-> state_ff == ST_IDLE, "byte taken while busy")
   `LARRS_ASSERT_IMPL(a_hold_out, clock, reset,
      (ov_ff && rsp_stall) |=> ov_ff, "descriptor dropped under stall")
   `LARRS_ASSERT_IMPL(a_idle_no_pend, clock, reset,
      (state_ff == ST_IDLE) |-> !rd_pend_ff, "stale scan read")
endmodule
`default_nettype wire

/* design/larrs_map.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// larrs_map
// Newline flag memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module larrs_map #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic          wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_data
);
   logic mem [DEPTH];

   // write flag; the read is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* bench/splitter_descriptor_check.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// splitter_descriptor_check
// Watches the byte, descriptor and register ports of the splitter, works out
// the descriptors each accepted byte must cause and compares them in order.
// ---------------------------------------------------------------------------
module splitter_descriptor_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_destination,
   input  logic [31:0] rsp_block_id,
   input  logic [39:0] rsp_start_offset,
   input  logic [16:0] rsp_block_length,
   input  logic        rsp_complete,
   input  logic        rsp_with_header,
   input  logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          descriptors_pending
);
   import larrs_pkg::*;

   typedef struct {
      logic [3:0]  dest;
      logic [31:0] id;
      logic [39:0] offset;
      logic [16:0] length;
      logic        complete;
      logic        header;
      logic        last;
   } descriptor_type;

   localparam int MAP_DEPTH = MAX_BATCH_DEF * MAX_OUTPUTS_DEF;

   descriptor_type descriptors_due[$];

   // Shadow of the stream state and the registers
   bit          newline_seen [MAP_DEPTH];
   int unsigned fill;
   int unsigned last_nl_pos;
   bit          last_nl_ok;
   bit          filling_initial;
   int unsigned cur_output;
   logic [31:0] block_count;
   int unsigned carried;
   logic [39:0] emit_offset;
   cfg_type     cfg;

   function automatic void clear_stream();
      fill = 0;
      last_nl_pos = 0;
      last_nl_ok = 0;
      filling_initial = 1;
      cur_output = 0;
      block_count = 0;
      carried = 0;
      emit_offset = 0;
   endfunction

   function automatic void add_descriptor(int unsigned dest, logic [31:0] id,
                                          logic [39:0] offset, int unsigned len,
                                          bit comp, bit hdr);
      descriptor_type d;
      d.dest = dest[3:0];
      d.id = id;
      d.offset = offset;
      d.length = len[16:0];
      d.complete = comp;
      d.header = hdr;
      d.last = 0;
      descriptors_due.push_back(d);
   endfunction

   // Deal the first buffer out as line-aligned shares
   function automatic void split_initial(int unsigned b, int unsigned nout, bit eos);
      int unsigned len, share, start, next, blen, stop, i;
      bit closes, found;
      len = fill;
      share = (len < b * nout) ? len / nout : b;
      start = 0;
      closes = 1;
      for (int unsigned k = 0; k < nout; k++) begin
         next = 0;
         if (k + 1 < nout) begin
            stop = (k + 1) * share;
            i = stop + 1;
            found = 0;
            while (i > start) begin
               i--;
               if (newline_seen[i]) begin
                  found = 1;
                  break;
               end
            end
            if (found) begin
               next = i + 1;
               blen = next - start;
            end else begin
               next = start;
               blen = 0;
            end
         end else begin
            blen = (len > start) ? len - start : 0;
            closes = (len > 0 && newline_seen[len - 1]) || eos;
         end
         add_descriptor(k, block_count, emit_offset + 40'(start), blen, closes,
                        cfg.header_enable);
         start = next;
         if (closes) block_count++;
      end
      cur_output = closes ? 0 : nout - 1;
      emit_offset = emit_offset + 40'(len);
   endfunction

   // Cut a batch after its last newline in the back half
   function automatic void split_batch(int unsigned nout, bit eos);
      int unsigned len, half, head, blen, dest;
      len = fill;
      half = (len > 0) ? (len - 1) / 2 : 0;
      dest = cur_output;
      if (len > 0 && last_nl_ok && last_nl_pos >= half) begin
         head = last_nl_pos + 1;
         blen = carried + head;
         add_descriptor(dest, block_count, emit_offset, blen, 1, cfg.header_enable);
         emit_offset = emit_offset + 40'(blen);
         cur_output = (cur_output + 1) % nout;
         carried = len - head;
         block_count++;
      end else begin
         blen = carried + len;
         add_descriptor(dest, block_count, emit_offset, blen, eos, cfg.header_enable);
         emit_offset = emit_offset + 40'(blen);
         carried = 0;
      end
      if (eos && carried > 0) begin
         add_descriptor(dest, block_count, emit_offset, carried, 1, cfg.header_enable);
         emit_offset = emit_offset + 40'(carried);
         carried = 0;
      end
   endfunction

   function automatic void predict_descriptors(logic [7:0] data, bit eos);
      int unsigned b, nout, due_before, blen;
      b = cfg.batch_len;
      nout = cfg.num_outputs;
      due_before = descriptors_due.size();
      if (b < 1) b = 1;
      if (b > MAX_BATCH_DEF) b = MAX_BATCH_DEF;
      if (nout < 1) nout = 1;
      if (nout > MAX_OUTPUTS_DEF) nout = MAX_OUTPUTS_DEF;

      if (fill < MAP_DEPTH) begin
         newline_seen[fill] = (data == NL_CHAR);
         if (data == NL_CHAR) begin
            last_nl_pos = fill;
            last_nl_ok = 1;
         end
         fill++;
      end

      if (cfg.byte_mode) begin
         if (fill >= b || eos) begin
            blen = carried + fill;
            add_descriptor(cur_output, block_count, emit_offset, blen, 1, 1);
            emit_offset = emit_offset + 40'(blen);
            block_count++;
            cur_output = (cur_output + 1) % nout;
            carried = 0;
            fill = 0;
            last_nl_ok = 0;
         end
      end else if (filling_initial) begin
         if (fill >= b * nout || eos) begin
            split_initial(b, nout, eos);
            filling_initial = 0;
            fill = 0;
            last_nl_ok = 0;
         end
      end else if (fill >= b || eos) begin
         split_batch(nout, eos);
         fill = 0;
         last_nl_ok = 0;
      end

      if (eos) clear_stream();
      if (descriptors_due.size() > due_before)
         descriptors_due[descriptors_due.size() - 1].last = 1;
   endfunction

   function automatic void report_mismatch(string what, longint unsigned exp_val,
                                           longint unsigned got_val);
      if (fail_count < 10)
         $display("descriptor mismatch on %s: expected %0h, got %0h",
                  what, exp_val, got_val);
      fail_count++;
   endfunction

   initial begin
      fail_count = 0;
      descriptors_pending = 0;
   end

   always @(posedge clock) begin
      descriptor_type d;
      if (reset) begin
         clear_stream();
         cfg.batch_len = 13'd4096;
         cfg.num_outputs = 5'd2;
         cfg.byte_mode = 1'b0;
         cfg.header_enable = 1'b1;
         descriptors_due.delete();
      end else begin
         // Compare a taken descriptor with the oldest one due
         if (rsp_valid && !rsp_stall) begin
            if (descriptors_due.size() == 0) begin
               if (fail_count < 10)
                  $display("descriptor with none due: dest %0d id %0h len %0d",
                           rsp_destination, rsp_block_id, rsp_block_length);
               fail_count++;
            end else begin
               d = descriptors_due.pop_front();
               if (rsp_destination !== d.dest)
                  report_mismatch("destination", d.dest, rsp_destination);
               if (rsp_block_id !== d.id)
                  report_mismatch("block_id", d.id, rsp_block_id);
               if (rsp_start_offset !== d.offset)
                  report_mismatch("start_offset", d.offset, rsp_start_offset);
               if (rsp_block_length !== d.length)
                  report_mismatch("block_length", d.length, rsp_block_length);
               if (rsp_complete !== d.complete)
                  report_mismatch("complete", d.complete, rsp_complete);
               if (rsp_with_header !== d.header)
                  report_mismatch("with_header", d.header, rsp_with_header);
               if (rsp_last_of_run !== d.last)
                  report_mismatch("last_of_run", d.last, rsp_last_of_run);
            end
         end
         // Predict from a taken word
         if (req_valid && !req_stall)
            predict_descriptors(req_data_byte, req_end_of_stream);
         // Track register writes; they apply from the next word
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_BATCH: cfg.batch_len = pwdata[12:0];
               REG_NOUT:  cfg.num_outputs = pwdata[4:0];
               REG_BMODE: cfg.byte_mode = pwdata[0];
               REG_HDR:   cfg.header_enable = pwdata[0];
               default: ;
            endcase
         end
      end
      descriptors_pending = descriptors_due.size();
   end
endmodule

/* bench/tb_line_aligned_round_robin_splitter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_line_aligned_round_robin_splitter
// Feeds byte streams under several register settings and idle patterns; a
// side checker predicts every descriptor and counts mismatches.
// ---------------------------------------------------------------------------
module tb_line_aligned_round_robin_splitter;
   import larrs_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int NUM_PHASES = 8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_end_of_stream;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_destination;
   logic [31:0] rsp_block_id;
   logic [39:0] rsp_start_offset;
   logic [16:0] rsp_block_length;
   logic        rsp_complete;
   logic        rsp_with_header;
   logic        rsp_last_of_run;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int descriptors_pending;
   int cycle_count;
   int words_sent;
   int tx_idle_pct;
   int rx_idle_pct;

   // Settings per phase: batch, outputs, byte mode, header, end-of-stream odds
   int unsigned phase_batch [NUM_PHASES] = '{4, 1, 0, 8191, 5, 6, 3, 2};
   int unsigned phase_nout  [NUM_PHASES] = '{3, 1, 0, 31, 16, 2, 16, 5};
   bit          phase_bmode [NUM_PHASES] = '{0, 1, 0, 0, 1, 0, 0, 0};
   bit          phase_hdr   [NUM_PHASES] = '{1, 1, 0, 1, 0, 0, 1, 1};
   int unsigned phase_eos   [NUM_PHASES] = '{12, 12, 10, 5, 12, 14, 16, 12};

   line_aligned_round_robin_splitter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_end_of_stream(req_end_of_stream),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_destination(rsp_destination), .rsp_block_id(rsp_block_id),
      .rsp_start_offset(rsp_start_offset), .rsp_block_length(rsp_block_length),
      .rsp_complete(rsp_complete), .rsp_with_header(rsp_with_header),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   splitter_descriptor_check check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_end_of_stream(req_end_of_stream),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_destination(rsp_destination), .rsp_block_id(rsp_block_id),
      .rsp_start_offset(rsp_start_offset), .rsp_block_length(rsp_block_length),
      .rsp_complete(rsp_complete), .rsp_with_header(rsp_with_header),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .descriptors_pending(descriptors_pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Stall the descriptor side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_line_aligned_round_robin_splitter NOT OK");
         $finish;
      end
   end

   // Pick the idle pattern from how far the stimulus has come
   function automatic void set_idling();
      if (words_sent < 100) begin
         tx_idle_pct = 26;
         rx_idle_pct = 70;
      end else if (words_sent < 200) begin
         tx_idle_pct = 70;
         rx_idle_pct = 26;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
   endfunction

   // Send one word and hold it until taken
   task automatic send_word(input logic [7:0] data, input logic eos);
      set_idling();
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Drain, let the block settle, then write a register
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (descriptors_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      int unsigned count;
      logic [7:0] data;
      bit eos;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      req_end_of_stream = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 4'd0;
      pwdata = 32'd0;
      cycle_count = 0;
      words_sent = 0;
      tx_idle_pct = 26;
      rx_idle_pct = 70;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default registers, byte extremes, a share with no newline
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(NL_CHAR, 1'b0);
      send_word(8'h41, 1'b1);
      send_word(NL_CHAR, 1'b1);
      send_word(8'h55, 1'b0);
      send_word(8'hAA, 1'b1);
      write_reg(REG_BATCH, 32'd3);
      write_reg(REG_NOUT, 32'd2);
      send_word(8'h61, 1'b0);
      send_word(NL_CHAR, 1'b0);
      send_word(8'h62, 1'b0);
      send_word(8'h63, 1'b0);
      send_word(8'h64, 1'b0);
      send_word(8'h65, 1'b0);
      send_word(8'h66, 1'b0);
      send_word(NL_CHAR, 1'b0);
      send_word(8'h67, 1'b0);
      send_word(8'h68, 1'b0);
      send_word(8'h69, 1'b0);
      send_word(8'h6A, 1'b1);

      // Random streams under each register setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(REG_BATCH, phase_batch[p]);
         write_reg(REG_NOUT, phase_nout[p]);
         write_reg(REG_BMODE, 32'(phase_bmode[p]));
         write_reg(REG_HDR, 32'(phase_hdr[p]));
         count = 36;
         for (int unsigned i = 0; i < count; i++) begin
            data = ($urandom_range(99) < 30) ? NL_CHAR : 8'($urandom_range(255));
            eos = ($urandom_range(phase_eos[p] - 1) == 0);
            // Close the long-buffer phase so its scan stays short
            if (phase_batch[p] > 4000 && i == count - 1) eos = 1;
            send_word(data, eos);
         end
      end
      req_valid <= 1'b0;

      // Wait for the last descriptors and a little more
      while (descriptors_pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && descriptors_pending == 0) begin
         $display("tb_line_aligned_round_robin_splitter OK");
      end else begin
         $display("tb_line_aligned_round_robin_splitter NOT OK");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+design
design/larrs_pkg.sv
design/larrs_map.sv
design/line_aligned_round_robin_splitter.sv
bench/splitter_descriptor_check.sv
bench/tb_line_aligned_round_robin_splitter.sv
